[rtl/stack_with_reverse_swap_search_top_defines.svh]
// Assertion macros shared by the stack RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef STACK_WITH_REVERSE_SWAP_SEARCH_TOP_DEFINES_SVH
`define STACK_WITH_REVERSE_SWAP_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/swrs_pkg.sv]
// Shared constants and types for the bounded stack block.
// No dependencies; imported by swrs_ram users and the top level.
package swrs_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 8;

  typedef logic signed [WORD_W-1:0] swrs_word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_SWAP     = 3'd2,
    CMD_REVERSE  = 3'd3,
    CMD_CONTAINS = 3'd4,
    CMD_CLEAR    = 3'd5
  } swrs_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_UNAVAIL = 2'd1,
    STAT_FULL    = 2'd2
  } swrs_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_LO,
    S_RD_HI,
    S_WR_LO,
    S_WR_HI,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FINISH
  } swrs_state_e;

endpackage

[rtl/swrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/stack_with_reverse_swap_search_top.sv]
// Top level of the bounded stack: command sequencer, entry RAM, result register.
// Depends on swrs_pkg, swrs_ram and stack_with_reverse_swap_search_top_defines.svh.
//
// Usage:
//   The slave channel carries one command per transaction: push, pop, swap of
//   bottom and top, reverse, contains (search) or clear, with a 32-bit word.
//   The master channel returns exactly one result transaction per command:
//   status, found flag and the occupancy after the command.
//   Entries live in a small RAM with one write and one registered read port;
//   a sequencer walks it, one access per cycle, sharing one comparator and one
//   pair of index counters.
//   Push, pop, clear and any rejected command go from decode to the result;
//   swap reads bottom and top and writes them back crossed, reverse does so
//   per pair moving inward, contains scans from the bottom to the first match.
//   One command is in flight at a time; s_axis_tready is high only while the
//   sequencer is idle, so the next command can be accepted in the cycle in
//   which the previous result is first presented on the master channel.
//   Reset clears the occupancy, the sequencer and the result valid; entry
//   contents are not cleared, none is read before it is pushed.
//   A stalled receiver holds the result in its register; the next command may
//   still be accepted and worked, and its result waits until the register frees.
module stack_with_reverse_swap_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] cmd, [34:3] value, [39:35] zero
  input  logic [swrs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] status, [2] found, [7:3] occupancy
  output logic [swrs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import swrs_pkg::*;
  `include "stack_with_reverse_swap_search_top_defines.svh"

  // Control state
  swrs_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          m_valid_q, m_valid_d;

  // Working payload
  swrs_cmd_e     cmd_q, cmd_d;
  swrs_word_t    value_q, value_d;
  swrs_word_t    tmp_q, tmp_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;
  swrs_status_e  status_q, status_d;
  logic          found_q, found_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  swrs_word_t    ram_wdata;
  logic [AW-1:0] ram_raddr;
  swrs_word_t    ram_rdata;

  // Shared index/compare unit
  logic          s_fire;
  logic          out_free;
  logic          cnt_zero;
  logic          cnt_lt2;
  logic          cnt_full;
  logic [AW-1:0] lo_inc;
  logic [AW-1:0] hi_dec;
  logic          more_pairs;
  logic          scan_match;
  logic          scan_last;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign cnt_zero   = (cnt_q == '0);
  assign cnt_lt2    = (cnt_q < CW'(2));
  assign cnt_full   = (cnt_q >= CW'(DEPTH));
  assign lo_inc     = lo_q + AW'(1);
  assign hi_dec     = hi_q - AW'(1);
  // Reverse keeps going while the inner pair still has two distinct slots
  assign more_pairs = (cmd_q == CMD_REVERSE) && (lo_inc < hi_dec);
  assign scan_match = (ram_rdata == value_q);
  assign scan_last  = ((CW'(lo_q) + CW'(1)) == cnt_q);

  swrs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_SWAP, CMD_REVERSE: begin
            state_d = cnt_lt2 ? S_FINISH : S_RD_LO;
          end
          CMD_CONTAINS: begin
            state_d = cnt_zero ? S_FINISH : S_SCAN_RD;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_RD_LO:    state_d = S_RD_HI;
      S_RD_HI:    state_d = S_WR_LO;
      S_WR_LO:    state_d = S_WR_HI;
      S_WR_HI:    state_d = more_pairs ? S_RD_LO : S_FINISH;
      S_SCAN_RD:  state_d = S_SCAN_CMP;
      S_SCAN_CMP: state_d = (scan_match || scan_last) ? S_FINISH : S_SCAN_RD;
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    value_d   = value_q;
    tmp_d     = tmp_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    status_d  = status_q;
    found_d   = found_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    ram_we    = 1'b0;
    ram_waddr = lo_q;
    ram_wdata = tmp_q;
    ram_raddr = lo_q;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          cmd_d    = swrs_cmd_e'(s_axis_tdata[CMD_W-1:0]);
          value_d  = s_axis_tdata[CMD_W +: WORD_W];
          status_d = STAT_DONE;
          found_d  = 1'b0;
        end
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_PUSH: begin
            if (cnt_full) begin
              status_d = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(cnt_q);
              ram_wdata = value_q;
              cnt_d     = cnt_q + CW'(1);
            end
          end
          CMD_POP: begin
            if (cnt_zero) begin
              status_d = STAT_UNAVAIL;
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
          end
          CMD_SWAP, CMD_REVERSE: begin
            if (cnt_lt2) begin
              status_d = STAT_UNAVAIL;
            end else begin
              lo_d = '0;
              hi_d = AW'(cnt_q - CW'(1));
            end
          end
          CMD_CONTAINS: begin
            if (cnt_zero) begin
              status_d = STAT_UNAVAIL;
            end else begin
              lo_d = '0;
            end
          end
          CMD_CLEAR: begin
            cnt_d = '0;
          end
          default: begin
            status_d = STAT_UNAVAIL;
          end
        endcase
      end
      S_RD_LO: begin
        ram_raddr = lo_q;
      end
      S_RD_HI: begin
        // Read data now holds the low entry; park it
        ram_raddr = hi_q;
        tmp_d     = ram_rdata;
      end
      S_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = ram_rdata;
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = tmp_q;
        if (more_pairs) begin
          lo_d = lo_inc;
          hi_d = hi_dec;
        end
      end
      S_SCAN_RD: begin
        ram_raddr = lo_q;
      end
      S_SCAN_CMP: begin
        if (scan_match) begin
          found_d = 1'b1;
        end else if (!scan_last) begin
          lo_d = lo_inc;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {OCC_W'(cnt_q), found_q, status_q};
        end
      end
      default: begin
        m_valid_d = m_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    value_q  <= value_d;
    tmp_q    <= tmp_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    status_q <= status_d;
    found_q  <= found_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `SWRS_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH), "occupancy above depth")
  `SWRS_ASSERT_NEXT(a_accept_decode, clk_i, rst_ni, s_fire, state_q == S_DECODE, "accept did not decode")
  `SWRS_ASSERT_NOW(a_pair_order, clk_i, rst_ni, state_q == S_RD_LO || state_q == S_WR_HI, lo_q < hi_q, "pair indexes crossed")
  `SWRS_ASSERT_NOW(a_scan_bound, clk_i, rst_ni, state_q == S_SCAN_RD, CW'(lo_q) < cnt_q, "scan past top")
  `SWRS_ASSERT_NOW(a_found_done, clk_i, rst_ni, m_valid_q && m_data_q[STATUS_W], m_data_q[STATUS_W-1:0] == STAT_DONE, "found with bad status")

endmodule
